// ===== hdl/msetb_pkg.sv =====
// Shared types and constants of the timer slot bank.
package msetb_pkg;

    localparam int CMD_W = 2;
    localparam int SLOT_FIELD_W = 4;
    localparam int TIME_W = 32;
    localparam int KIND_W = 2;
    localparam int STATUS_W = 2;
    localparam int MAX_RES = 16;
    localparam int RES_CNT_W = 5;

    localparam logic [CMD_W-1:0] CMD_ADD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd3;

    localparam logic [KIND_W-1:0] KIND_ADD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EXPIRY = 2'd2;
    localparam logic [KIND_W-1:0] KIND_PROGRESS = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_SLOT = 2'd2;

    typedef struct packed {
        logic load;
        logic reply;
        logic step;
        logic flush;
    } ctl_t;

    typedef struct packed {
        logic out_free;
        logic stall;
        logic sweep_end;
        logic stage_valid;
    } sts_t;

endpackage

// ===== hdl/msetb_ifs.sv =====
// Valid/ready channel interfaces for the command and result streams.
interface msetb_in_if;
    logic valid;
    logic ready;
    logic [1:0] command;
    logic [3:0] slot;
    logic [31:0] period;
    logic repeat_req;
    logic [31:0] delta;

    modport source (output valid, output command, output slot, output period,
                    output repeat_req, output delta, input ready);
    modport sink (input valid, input command, input slot, input period,
                  input repeat_req, input delta, output ready);
endinterface

interface msetb_out_if;
    logic valid;
    logic ready;
    logic [1:0] kind;
    logic [3:0] slot_out;
    logic [1:0] status;
    logic [31:0] progress;
    logic last;

    modport source (output valid, output kind, output slot_out, output status,
                    output progress, output last, input ready);
    modport sink (input valid, input kind, input slot_out, input status,
                  input progress, input last, output ready);
endinterface

// ===== hdl/multi_slot_event_timer_bank.sv =====
// Top level of the timer slot bank: controller, datapath and checks.
//
//   Channel  Role    Transfer carries
//   req      sink    command, slot, period, repeat_req, delta
//   rsp      source  kind, slot_out, status, progress, last
//
// Add, remove and query wait in the REPLY state until rsp is free; the result is then registered.
// A tick sweeps the slot table through the RAM's read and write ports, one slot per
// cycle while rsp does not stall a pending expiry, then flushes the last staged expiry.
// The block takes a new command only when the previous one has fully finished.
// Reset clears the used flags and all control state; the table RAM is not cleared.
module multi_slot_event_timer_bank #(
    parameter int NUM_SLOTS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    msetb_in_if.sink   req,
    msetb_out_if.source rsp
);
    import msetb_pkg::*;

    ctl_t ctl;
    sts_t sts;

    msetb_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req.valid),
        .req_is_tick (req.command == CMD_TICK),
        .req_ready   (req.ready),
        .sts         (sts),
        .ctl         (ctl)
    );

    msetb_dp #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .sts        (sts),
        .command    (req.command),
        .slot       (req.slot),
        .period     (req.period),
        .repeat_req (req.repeat_req),
        .delta      (req.delta),
        .out_valid  (rsp.valid),
        .out_ready  (rsp.ready),
        .kind       (rsp.kind),
        .slot_out   (rsp.slot_out),
        .status     (rsp.status),
        .progress   (rsp.progress),
        .last       (rsp.last)
    );

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("command accepted while the previous one is still in progress");

    a_reply_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.kind != KIND_EXPIRY) |-> rsp.last)
        else $error("single reply without last mark");

    a_expiry_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.kind == KIND_EXPIRY) |-> (rsp.status == STATUS_OK && rsp.progress == '0))
        else $error("expiry result with nonzero status or progress");

    a_full_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == STATUS_FULL) |-> (rsp.kind == KIND_ADD && rsp.slot_out == '0))
        else $error("table full status on a wrong result");

endmodule

// ===== hdl/msetb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module msetb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/msetb_ctrl.sv =====
// Controller state machine that sequences replies and the tick sweep.
module msetb_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic          req_is_tick,
    output logic          req_ready,
    input  msetb_pkg::sts_t sts,
    output msetb_pkg::ctl_t ctl
);
    import msetb_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_REPLY = 4'b0010,
        ST_SWEEP = 4'b0100,
        ST_FLUSH = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl = '0;
        req_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    ctl.load = 1'b1;
                    state_next = req_is_tick ? ST_SWEEP : ST_REPLY;
                end
            end
            ST_REPLY:
            begin
                if (sts.out_free)
                begin
                    ctl.reply = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SWEEP:
            begin
                ctl.step = 1'b1;
                if (!sts.stall && sts.sweep_end)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!sts.stage_valid)
                begin
                    state_next = ST_IDLE;
                end
                else if (sts.out_free)
                begin
                    ctl.flush = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/msetb_dp.sv =====
// Datapath: slot table, tick arithmetic, expiry staging and result register.
module msetb_dp #(
    parameter int NUM_SLOTS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  msetb_pkg::ctl_t                      ctl,
    output msetb_pkg::sts_t                      sts,
    input  logic [msetb_pkg::CMD_W-1:0]          command,
    input  logic [msetb_pkg::SLOT_FIELD_W-1:0]   slot,
    input  logic [msetb_pkg::TIME_W-1:0]         period,
    input  logic                                 repeat_req,
    input  logic [msetb_pkg::TIME_W-1:0]         delta,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [msetb_pkg::KIND_W-1:0]         kind,
    output logic [msetb_pkg::SLOT_FIELD_W-1:0]   slot_out,
    output logic [msetb_pkg::STATUS_W-1:0]       status,
    output logic [msetb_pkg::TIME_W-1:0]         progress,
    output logic                                 last
);
    import msetb_pkg::*;

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int CMP_W = ((SLOT_W > SLOT_FIELD_W) ? SLOT_W : SLOT_FIELD_W) + 1;
    localparam int WORD_W = 1 + 2 * TIME_W;

    logic [NUM_SLOTS-1:0] used_reg, used_next;
    logic [CMD_W-1:0] cmd_reg, cmd_next;
    logic [SLOT_FIELD_W-1:0] slot_reg, slot_next;
    logic [SLOT_W-1:0] slot_idx_reg, slot_idx_next;
    logic in_range_reg, in_range_next;
    logic [TIME_W-1:0] period_reg, period_next;
    logic repeat_reg, repeat_next;
    logic [TIME_W-1:0] delta_reg, delta_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic stage_valid_reg, stage_valid_next;
    logic [SLOT_W-1:0] stage_idx_reg, stage_idx_next;
    logic [RES_CNT_W-1:0] res_cnt_reg, res_cnt_next;
    logic out_valid_reg, out_valid_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [SLOT_FIELD_W-1:0] slot_out_reg, slot_out_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [TIME_W-1:0] progress_reg, progress_next;
    logic last_reg, last_next;

    logic [CMP_W-1:0] slot_wide;
    logic [CMP_W-1:0] stage_wide;
    logic [CMP_W-1:0] free_wide;
    logic in_range_now;
    logic ram_we, ram_re;
    logic [SLOT_W-1:0] ram_waddr, ram_raddr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;
    logic rd_repeat;
    logic [TIME_W-1:0] rd_period, rd_elapsed;
    logic [TIME_W:0] sum;
    logic [TIME_W-1:0] sat_elapsed;
    logic cur_used, hit, report, out_free, stall, step_go, sweep_end;
    logic free_found;
    logic [SLOT_W-1:0] free_idx;
    logic slot_ok;

    msetb_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign slot_wide = CMP_W'(slot);
    assign in_range_now = slot_wide < CMP_W'(NUM_SLOTS);
    assign {rd_repeat, rd_period, rd_elapsed} = ram_rdata;

    assign sum = {1'b0, rd_elapsed} + {1'b0, delta_reg};
    assign sat_elapsed = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
    assign cur_used = used_reg[idx_reg];
    assign hit = cur_used && (sat_elapsed >= rd_period);
    assign report = hit && (res_cnt_reg < RES_CNT_W'(MAX_RES));
    assign out_free = !out_valid_reg || out_ready;
    assign stall = report && stage_valid_reg && !out_free;
    assign step_go = ctl.step && !stall;
    assign sweep_end = idx_reg == SLOT_W'(NUM_SLOTS - 1);
    assign slot_ok = in_range_reg && used_reg[slot_idx_reg];

    assign stage_wide = CMP_W'(stage_idx_reg);
    assign free_wide = CMP_W'(free_idx);

    always_comb
    begin
        free_found = 1'b0;
        free_idx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_found = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        used_next = used_reg;
        cmd_next = cmd_reg;
        slot_next = slot_reg;
        slot_idx_next = slot_idx_reg;
        in_range_next = in_range_reg;
        period_next = period_reg;
        repeat_next = repeat_reg;
        delta_next = delta_reg;
        idx_next = idx_reg;
        stage_valid_next = stage_valid_reg;
        stage_idx_next = stage_idx_reg;
        res_cnt_next = res_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        kind_next = kind_reg;
        slot_out_next = slot_out_reg;
        status_next = status_reg;
        progress_next = progress_reg;
        last_next = last_reg;
        ram_we = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = {rd_repeat, rd_period, sat_elapsed};
        ram_re = 1'b0;
        ram_raddr = SLOT_W'(idx_reg + 1'b1);

        if (ctl.load)
        begin
            cmd_next = command;
            slot_next = slot;
            slot_idx_next = slot_wide[SLOT_W-1:0];
            in_range_next = in_range_now;
            period_next = period;
            repeat_next = repeat_req;
            delta_next = delta;
            idx_next = '0;
            stage_valid_next = 1'b0;
            res_cnt_next = '0;
            ram_re = (command == CMD_TICK) || in_range_now;
            ram_raddr = (command == CMD_TICK) ? '0 : slot_wide[SLOT_W-1:0];
        end

        if (ctl.reply)
        begin
            out_valid_next = 1'b1;
            last_next = 1'b1;
            progress_next = '0;
            status_next = STATUS_OK;
            slot_out_next = slot_reg;
            unique case (cmd_reg)
                CMD_ADD:
                begin
                    kind_next = KIND_ADD;
                    if (free_found)
                    begin
                        slot_out_next = free_wide[SLOT_FIELD_W-1:0];
                        used_next[free_idx] = 1'b1;
                        ram_we = 1'b1;
                        ram_waddr = free_idx;
                        ram_wdata = {repeat_reg, period_reg, {TIME_W{1'b0}}};
                    end
                    else
                    begin
                        slot_out_next = '0;
                        status_next = STATUS_FULL;
                    end
                end
                CMD_REMOVE:
                begin
                    kind_next = KIND_REMOVE;
                    if (slot_ok)
                    begin
                        used_next[slot_idx_reg] = 1'b0;
                    end
                    else
                    begin
                        status_next = STATUS_BAD_SLOT;
                    end
                end
                CMD_QUERY:
                begin
                    kind_next = KIND_PROGRESS;
                    if (slot_ok)
                    begin
                        progress_next = rd_elapsed;
                    end
                    else
                    begin
                        status_next = STATUS_BAD_SLOT;
                    end
                end
                default:
                begin
                    kind_next = KIND_EXPIRY;
                end
            endcase
        end

        if (step_go)
        begin
            ram_re = !sweep_end;
            idx_next = SLOT_W'(idx_reg + 1'b1);
            if (cur_used)
            begin
                ram_we = 1'b1;
                if (hit && rd_repeat)
                begin
                    ram_wdata = {rd_repeat, rd_period, sat_elapsed - rd_period};
                end
                if (hit && !rd_repeat)
                begin
                    used_next[idx_reg] = 1'b0;
                end
            end
            if (report)
            begin
                if (stage_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    kind_next = KIND_EXPIRY;
                    slot_out_next = stage_wide[SLOT_FIELD_W-1:0];
                    status_next = STATUS_OK;
                    progress_next = '0;
                    last_next = 1'b0;
                end
                stage_valid_next = 1'b1;
                stage_idx_next = idx_reg;
                res_cnt_next = res_cnt_reg + 1'b1;
            end
        end

        if (ctl.flush)
        begin
            out_valid_next = 1'b1;
            kind_next = KIND_EXPIRY;
            slot_out_next = stage_wide[SLOT_FIELD_W-1:0];
            status_next = STATUS_OK;
            progress_next = '0;
            last_next = 1'b1;
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            stage_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            res_cnt_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            used_reg <= used_next;
            stage_valid_reg <= stage_valid_next;
            out_valid_reg <= out_valid_next;
            res_cnt_reg <= res_cnt_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        slot_reg <= slot_next;
        slot_idx_reg <= slot_idx_next;
        in_range_reg <= in_range_next;
        period_reg <= period_next;
        repeat_reg <= repeat_next;
        delta_reg <= delta_next;
        stage_idx_reg <= stage_idx_next;
        kind_reg <= kind_next;
        slot_out_reg <= slot_out_next;
        status_reg <= status_next;
        progress_reg <= progress_next;
        last_reg <= last_next;
    end

    assign sts.out_free = out_free;
    assign sts.stall = stall;
    assign sts.sweep_end = sweep_end;
    assign sts.stage_valid = stage_valid_reg;

    assign out_valid = out_valid_reg;
    assign kind = kind_reg;
    assign slot_out = slot_out_reg;
    assign status = status_reg;
    assign progress = progress_reg;
    assign last = last_reg;

endmodule

// ===== bench/multi_slot_event_timer_bank_tb.sv =====
// Self-checking testbench for the timer slot bank with directed and random commands and bursty handshakes.
module multi_slot_event_timer_bank_tb;
    import msetb_pkg::*;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [SLOT_FIELD_W-1:0] slot;
        logic [TIME_W-1:0] period;
        logic repeat_req;
        logic [TIME_W-1:0] delta;
    } timer_cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SLOT_FIELD_W-1:0] slot_out;
        logic [STATUS_W-1:0] status;
        logic [TIME_W-1:0] progress;
        logic last;
    } timer_event_t;

    class timer_bank_scoreboard #(int SLOTS = 16);
        bit armed[SLOTS];
        bit reload[SLOTS];
        logic [TIME_W-1:0] duration[SLOTS];
        logic [TIME_W-1:0] elapsed[SLOTS];
        timer_event_t pending_events[$];
        int mismatches;

        task report_mismatch(string msg);
            if (mismatches < 50)
                $display("mismatch at %0t: %s", $time, msg);
            mismatches++;
        endtask

        function int outstanding();
            return pending_events.size();
        endfunction

        function logic [SLOT_FIELD_W-1:0] choose_slot();
            int busy[$];
            for (int i = 0; i < SLOTS; i++)
                if (armed[i])
                    busy.push_back(i);
            if (busy.size() > 0 && $urandom_range(0, 4) != 0)
                return SLOT_FIELD_W'(busy[$urandom_range(0, busy.size() - 1)]);
            return SLOT_FIELD_W'($urandom_range(0, 15));
        endfunction

        function void note_command(timer_cmd_t c);
            timer_event_t ev;
            logic [TIME_W:0] sum;
            logic [TIME_W-1:0] e;
            bit present;
            bit placed;
            int fired;
            ev = '0;
            ev.last = 1'b1;
            present = (int'(c.slot) < SLOTS) && armed[c.slot];
            unique case (c.command)
                CMD_ADD:
                begin
                    ev.kind = KIND_ADD;
                    ev.status = STATUS_FULL;
                    placed = 1'b0;
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (!placed && !armed[i])
                        begin
                            armed[i] = 1'b1;
                            reload[i] = c.repeat_req;
                            duration[i] = c.period;
                            elapsed[i] = '0;
                            ev.slot_out = SLOT_FIELD_W'(i);
                            ev.status = STATUS_OK;
                            placed = 1'b1;
                        end
                    end
                    pending_events.push_back(ev);
                end
                CMD_REMOVE:
                begin
                    ev.kind = KIND_REMOVE;
                    ev.slot_out = c.slot;
                    ev.status = present ? STATUS_OK : STATUS_BAD_SLOT;
                    if (present)
                        armed[c.slot] = 1'b0;
                    pending_events.push_back(ev);
                end
                CMD_QUERY:
                begin
                    ev.kind = KIND_PROGRESS;
                    ev.slot_out = c.slot;
                    ev.status = present ? STATUS_OK : STATUS_BAD_SLOT;
                    ev.progress = present ? elapsed[c.slot] : '0;
                    pending_events.push_back(ev);
                end
                default:
                begin
                    fired = 0;
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (armed[i])
                        begin
                            sum = {1'b0, elapsed[i]} + {1'b0, c.delta};
                            e = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
                            if (e >= duration[i])
                            begin
                                if (fired < MAX_RES)
                                begin
                                    ev = '0;
                                    ev.kind = KIND_EXPIRY;
                                    ev.slot_out = SLOT_FIELD_W'(i);
                                    pending_events.push_back(ev);
                                    fired++;
                                end
                                if (reload[i])
                                    e = e - duration[i];
                                else
                                    armed[i] = 1'b0;
                            end
                            elapsed[i] = e;
                        end
                    end
                    if (fired > 0)
                        pending_events[pending_events.size() - 1].last = 1'b1;
                end
            endcase
        endfunction

        task check_result(timer_event_t got);
            timer_event_t want;
            if (pending_events.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result kind %0d slot %0d",
                                          got.kind, got.slot_out));
                return;
            end
            want = pending_events.pop_front();
            if (got.kind !== want.kind)
                report_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
            if (got.slot_out !== want.slot_out)
                report_mismatch($sformatf("slot_out %0d, expected %0d",
                                          got.slot_out, want.slot_out));
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, expected %0d",
                                          got.status, want.status));
            if (got.progress !== want.progress)
                report_mismatch($sformatf("progress %h, expected %h",
                                          got.progress, want.progress));
            if (got.last !== want.last)
                report_mismatch($sformatf("last %b, expected %b", got.last, want.last));
        endtask
    endclass

    localparam int NUM_SLOTS = 16;
    localparam int RANDOM_ITEMS = 445;
    localparam int QUIET_LIMIT = 2000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic [9:0] rx_cycle = '0;
    int quiet_cycles = 0;
    int burst_left = 0;

    timer_bank_scoreboard #(NUM_SLOTS) sb;

    msetb_in_if req_ch ();
    msetb_out_if rsp_ch ();

    multi_slot_event_timer_bank #(
        .NUM_SLOTS(NUM_SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_ch),
        .rsp(rsp_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 1'b1;
        unique case (rx_cycle[9:8])
            2'd0: rsp_ch.ready <= 1'b1;
            2'd1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            2'd2: rsp_ch.ready <= (rx_cycle[3:0] >= 4'd12);
            default: rsp_ch.ready <= rx_cycle[1];
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_result({rsp_ch.kind, rsp_ch.slot_out, rsp_ch.status,
                             rsp_ch.progress, rsp_ch.last});
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic timer_cmd_t make_cmd(logic [CMD_W-1:0] command,
                                            logic [SLOT_FIELD_W-1:0] slot,
                                            logic [TIME_W-1:0] period,
                                            logic repeat_req,
                                            logic [TIME_W-1:0] delta);
        timer_cmd_t c;
        c.command = command;
        c.slot = slot;
        c.period = period;
        c.repeat_req = repeat_req;
        c.delta = delta;
        return c;
    endfunction

    function automatic logic [TIME_W-1:0] pick_duration();
        unique case ($urandom_range(0, 9))
            0: return $urandom;
            1: return '0;
            2: return '1;
            default: return $urandom_range(1, 60);
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] pick_delta();
        unique case ($urandom_range(0, 11))
            0: return $urandom;
            1: return '1;
            2: return '0;
            default: return $urandom_range(1, 30);
        endcase
    endfunction

    function automatic timer_cmd_t random_cmd();
        timer_cmd_t c;
        int r;
        c = make_cmd(CMD_TICK, SLOT_FIELD_W'($urandom_range(0, 15)), $urandom,
                     1'($urandom_range(0, 1)), $urandom);
        r = $urandom_range(0, 99);
        if (r < 30)
        begin
            c.command = CMD_ADD;
            c.period = pick_duration();
        end
        else if (r < 45)
        begin
            c.command = CMD_REMOVE;
            c.slot = sb.choose_slot();
        end
        else if (r < 75)
        begin
            c.command = CMD_TICK;
            c.delta = pick_delta();
        end
        else
        begin
            c.command = CMD_QUERY;
            c.slot = sb.choose_slot();
        end
        return c;
    endfunction

    // The sender works in bursts; valid stays high inside a burst.
    task automatic issue(input timer_cmd_t c);
        int gap;
        req_ch.valid <= 1'b1;
        req_ch.command <= c.command;
        req_ch.slot <= c.slot;
        req_ch.period <= c.period;
        req_ch.repeat_req <= c.repeat_req;
        req_ch.delta <= c.delta;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.note_command(c);
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            burst_left = $urandom_range(1, 12);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        else
        begin
            burst_left--;
        end
    endtask

    task automatic run_directed();
        logic [TIME_W-1:0] dur;
        logic rep;
        issue(make_cmd(CMD_QUERY, 4'd3, '0, 1'b0, '0));
        issue(make_cmd(CMD_REMOVE, 4'd15, '1, 1'b1, '1));
        issue(make_cmd(CMD_TICK, 4'd0, '0, 1'b0, 32'd5));
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            dur = (i == 0) ? '0 : (i == 1) ? '1 : (i == 2) ? 32'd5 : TIME_W'(i * 3);
            rep = (i == 1) ? 1'b0 : (i <= 2) ? 1'b1 : 1'(i % 2);
            issue(make_cmd(CMD_ADD, 4'd0, dur, rep, '0));
        end
        issue(make_cmd(CMD_ADD, 4'd7, 32'd9, 1'b1, '0));
        issue(make_cmd(CMD_TICK, 4'd0, '0, 1'b0, '1));
        issue(make_cmd(CMD_QUERY, 4'd2, '0, 1'b0, '0));
        issue(make_cmd(CMD_TICK, 4'd0, '0, 1'b0, '1));
        issue(make_cmd(CMD_QUERY, 4'd2, '0, 1'b0, '0));
        issue(make_cmd(CMD_REMOVE, 4'd2, '0, 1'b0, '0));
    endtask

    initial
    begin
        sb = new;
        req_ch.valid <= 1'b0;
        req_ch.command <= CMD_ADD;
        req_ch.slot <= '0;
        req_ch.period <= '0;
        req_ch.repeat_req <= 1'b0;
        req_ch.delta <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        for (int n = 0; n < RANDOM_ITEMS; n++)
            issue(random_cmd());
        req_ch.valid <= 1'b0;
        while (sb.outstanding() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (sb.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
